### rtl/cgo_pkg.sv
package cgo_pkg;

    localparam int CW = 13;                       // width of frame sizes and coordinates
    localparam logic [CW-1:0] MAX_SIDE = 13'd4096;
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    // divide by 100 for values below 4096: (v * RECIP100) >> QSHIFT
    localparam logic [10:0] RECIP100 = 11'd1311;
    localparam int QSHIFT = 17;

    localparam logic [7:0] GRID_ALPHA = 8'd112;
    localparam logic [7:0] TICK_ALPHA = 8'd176;
    localparam logic [7:0] BOX_ALPHA  = 8'd208;
    localparam logic [7:0] TICK_GREEN = 8'd224;

    typedef struct packed {
        logic gx;
        logic gy;
        logic cbox;
        logic cglyph;
        logic rbox;
        logic rglyph;
        logic ttop;
        logic tbot;
        logic tleft;
        logic tright;
    } t_marks;

    // (old*(255-a) + c*a + 127) / 255, exact for sums below 65535
    function automatic logic [7:0] blend_ch(input logic [7:0] old, input logic [7:0] c,
                                            input logic [7:0] a);
        logic [16:0] t;
        logic [16:0] s;
        t = 17'(old) * 17'(8'd255 - a) + 17'(c) * 17'(a) + 17'd127;
        s = t + (t >> 8) + 17'd1;
        return s[15:8];
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] px, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input logic [7:0] a);
        return {px[31:24], blend_ch(px[23:16], b, a), blend_ch(px[15:8], g, a),
                blend_ch(px[7:0], r, a)};
    endfunction

endpackage

### rtl/coordinate_grid_overlay_unit.sv
// Coordinate overlay for a pixel stream: each pixel word (x, y, RGBA) comes out with
// cyan grid lines every 100 pixels, boxed decimal labels for them and yellow edge ticks
// every 25 pixels blended over it; alpha is kept and pixels outside the frame pass
// untouched. The block takes one word per clock while its output is taken and passes each
// word through seven pipeline registers (three for the divide by 100 and label hit tests,
// four for the chain of blends). When the output is not taken the whole pipeline holds.
// The user must write frame width and height on the config port only while no word is in
// flight; the block does not enforce this. Values above 4096 are held at 4096.
module coordinate_grid_overlay_unit import cgo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic [31:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pixel_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    logic [CW-1:0] r_width, r_height;
    logic [CW-1:0] w_cfg_val;
    logic          w_adv;
    logic          w_lv;
    logic [31:0]   w_lpx;
    t_marks        w_marks;

    assign w_adv     = !o_valid || i_ready;
    assign o_ready   = w_adv;
    assign w_cfg_val = (i_cfg_data > MAX_SIDE) ? MAX_SIDE : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd640;
            r_height <= 13'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= w_cfg_val;
                CFG_HEIGHT: r_height <= w_cfg_val;
                default: begin
                end
            endcase
        end
    end

    cgo_locate u_locate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_valid),
        .i_x      (i_pixel_x),
        .i_y      (i_pixel_y),
        .i_px     (i_pixel_in),
        .i_width  (r_width),
        .i_height (r_height),
        .o_valid  (w_lv),
        .o_px     (w_lpx),
        .o_marks  (w_marks)
    );

    cgo_compose u_compose (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_lv),
        .i_px    (w_lpx),
        .i_marks (w_marks),
        .o_valid (o_valid),
        .o_px    (o_pixel_out)
    );

endmodule

### rtl/cgo_locate.sv
module cgo_locate import cgo_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  logic [11:0]   i_x,
    input  logic [11:0]   i_y,
    input  logic [31:0]   i_px,
    input  logic [CW-1:0] i_width,
    input  logic [CW-1:0] i_height,
    output logic          o_valid,
    output logic [31:0]   o_px,
    output t_marks        o_marks
);

    typedef struct packed {
        logic          ok;
        logic [6:0]    q;
        logic [5:0]    lw;
        logic [CW-1:0] lx;
        logic [CW-1:0] ly;
    } t_label;

    function automatic logic [5:0] lw_of(input logic [6:0] q);
        if (q == 7'd0) begin
            return 6'd8;
        end else if (q < 7'd10) begin
            return 6'd24;
        end
        return 6'd32;
    endfunction

    function automatic logic [2:0] glyph_row(input logic [3:0] dv, input logic [2:0] row);
        logic [14:0] g;
        case (dv)
            4'd0:    g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1:    g = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
            4'd2:    g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd3:    g = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
            4'd4:    g = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
            4'd5:    g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd6:    g = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
            4'd7:    g = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
            4'd8:    g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9:    g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
            default: g = '0;
        endcase
        case (row)
            3'd0:    return g[14:12];
            3'd1:    return g[11:9];
            3'd2:    return g[8:6];
            3'd3:    return g[5:3];
            3'd4:    return g[2:0];
            default: return 3'd0;
        endcase
    endfunction

    // value shown is 100*q: digits are q (or its tens and ones) followed by zeros
    function automatic logic glyph_bit(input logic [6:0] q, input logic [4:0] rx,
                                       input logic [3:0] ry);
        logic [17:0] tp;
        logic [3:0]  tens;
        logic [3:0]  ones;
        logic [3:0]  dv;
        logic [2:0]  cx;
        logic [2:0]  cxm;
        logic [3:0]  rym;
        logic [2:0]  bits;
        tp   = 18'(q) * 18'd205;
        tens = 4'(tp >> 11);
        ones = 4'(q - 7'(tens) * 7'd10);
        cx   = rx[2:0];
        if (q < 7'd10) begin
            dv = (rx[4:3] == 2'd0) ? q[3:0] : 4'd0;
        end else begin
            dv = (rx[4:3] == 2'd0) ? tens : ((rx[4:3] == 2'd1) ? ones : 4'd0);
        end
        if (cx < 3'd1 || cx > 3'd6 || ry < 4'd1 || ry > 4'd10) begin
            return 1'b0;
        end
        cxm  = cx - 3'd1;
        rym  = ry - 4'd1;
        bits = glyph_row(dv, rym[3:1]);
        return bits[2'd2 - cxm[2:1]];
    endfunction

    // stage 1: quotients by 100
    logic          r1_v, r1_in;
    logic [11:0]   r1_x, r1_y;
    logic [31:0]   r1_px;
    logic [6:0]    r1_qx, r1_qy, r1_qw, r1_qh;
    logic [22:0]   w_mx, w_my;
    logic [23:0]   w_mw, w_mh;

    assign w_mx = 23'(i_x) * 23'(RECIP100);
    assign w_my = 23'(i_y) * 23'(RECIP100);
    assign w_mw = 24'(i_width - 13'd1) * 24'(RECIP100);
    assign w_mh = 24'(i_height - 13'd1) * 24'(RECIP100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
        end
        if (i_adv) begin
            r1_x  <= i_x;
            r1_y  <= i_y;
            r1_px <= i_px;
            r1_in <= (13'(i_x) < i_width) && (13'(i_y) < i_height);
            r1_qx <= 7'(w_mx >> QSHIFT);
            r1_qy <= 7'(w_my >> QSHIFT);
            r1_qw <= 7'(w_mw >> QSHIFT);
            r1_qh <= 7'(w_mh >> QSHIFT);
        end
    end

    // stage 2: remainders, label placement, grid and tick marks
    logic [6:0]    w_rx, w_ry;
    logic [6:0]    w_aqx, w_aqy;
    logic          w_tx, w_ty;
    logic [CW-1:0] w_xx, w_yy, w_cly;
    logic [6:0]    w_q [4];
    logic          w_base [4];
    t_label        n_lab [4];
    t_marks        n2_m;
    logic          r2_v;
    logic [11:0]   r2_x, r2_y;
    logic [31:0]   r2_px;
    t_label        r2_lab [4];
    t_marks        r2_m;

    assign w_xx  = 13'(r1_x);
    assign w_yy  = 13'(r1_y);
    assign w_rx  = 7'(w_xx - 13'(r1_qx) * 13'd100);
    assign w_ry  = 7'(w_yy - 13'(r1_qy) * 13'd100);
    assign w_aqx = (w_rx >= 7'd2) ? r1_qx : r1_qx - 7'd1;
    assign w_aqy = (w_ry >= 7'd2) ? r1_qy : r1_qy - 7'd1;
    assign w_tx  = (w_rx == 7'd25) || (w_rx == 7'd50) || (w_rx == 7'd75);
    assign w_ty  = (w_ry == 7'd25) || (w_ry == 7'd50) || (w_ry == 7'd75);
    assign w_cly = (i_height < 13'd14) ? i_height - 13'd12 : 13'd2;

    // column labels: nearest one left of the pixel and the last one; rows likewise
    assign w_q[0]    = w_aqx;
    assign w_q[1]    = r1_qw;
    assign w_q[2]    = w_aqy;
    assign w_q[3]    = r1_qh;
    assign w_base[0] = r1_in && (r1_x >= 12'd2);
    assign w_base[1] = r1_in;
    assign w_base[2] = r1_in && (r1_y >= 12'd2) && (w_aqy != 7'd0);
    assign w_base[3] = r1_in && (r1_qh != 7'd0);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [CW-1:0] req;
            logic [CW-1:0] lim;
            n_lab[k].q  = w_q[k];
            n_lab[k].lw = lw_of(w_q[k]);
            n_lab[k].ok = w_base[k] && (13'(n_lab[k].lw) <= i_width) && (i_height >= 13'd12);
            req = 13'(w_q[k]) * 13'd100 + 13'd2;
            if (k < 2) begin
                lim = i_width - 13'(n_lab[k].lw);
                n_lab[k].lx = (req < lim) ? req : lim;
                n_lab[k].ly = w_cly;
            end else begin
                lim = i_height - 13'd12;
                n_lab[k].ly = (req < lim) ? req : lim;
                lim = i_width - 13'(n_lab[k].lw);
                n_lab[k].lx = (lim < 13'd2) ? lim : 13'd2;
            end
        end
        n2_m        = '0;
        n2_m.gx     = r1_in && (w_rx == 7'd0);
        n2_m.gy     = r1_in && (w_ry == 7'd0);
        n2_m.ttop   = r1_in && w_tx && (r1_y < 12'd7);
        n2_m.tbot   = r1_in && w_tx && (i_height > 13'd7) && (w_yy >= i_height - 13'd7);
        n2_m.tleft  = r1_in && w_ty && (r1_x < 12'd7);
        n2_m.tright = r1_in && w_ty && (i_width > 13'd7) && (w_xx >= i_width - 13'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_adv) begin
            r2_v <= r1_v;
        end
        if (i_adv) begin
            r2_x   <= r1_x;
            r2_y   <= r1_y;
            r2_px  <= r1_px;
            r2_lab <= n_lab;
            r2_m   <= n2_m;
        end
    end

    // stage 3: box and glyph hits
    logic   w_box [4];
    logic   w_gly [4];
    t_marks n3_m;
    logic   r3_v;
    logic [31:0] r3_px;
    t_marks r3_m;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [CW-1:0] dx;
            logic [CW-1:0] dy;
            dx = 13'(r2_x) - r2_lab[k].lx;
            dy = 13'(r2_y) - r2_lab[k].ly;
            w_box[k] = r2_lab[k].ok && (13'(r2_x) >= r2_lab[k].lx) &&
                       (dx < 13'(r2_lab[k].lw)) && (13'(r2_y) >= r2_lab[k].ly) &&
                       (dy < 13'd12);
            w_gly[k] = w_box[k] && glyph_bit(r2_lab[k].q, dx[4:0], dy[3:0]);
        end
        n3_m        = r2_m;
        n3_m.cbox   = w_box[0] || w_box[1];
        n3_m.cglyph = w_gly[0] || w_gly[1];
        n3_m.rbox   = w_box[2] || w_box[3];
        n3_m.rglyph = w_gly[2] || w_gly[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_adv) begin
            r3_v <= r2_v;
        end
        if (i_adv) begin
            r3_px <= r2_px;
            r3_m  <= n3_m;
        end
    end

    assign o_valid = r3_v;
    assign o_px    = r3_px;
    assign o_marks = r3_m;

endmodule

### rtl/cgo_compose.sv
module cgo_compose import cgo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic [31:0] i_px,
    input  t_marks      i_marks,
    output logic        o_valid,
    output logic [31:0] o_px
);

    localparam logic [31:0] WHITE_RGB = 32'h00FF_FFFF;

    logic [31:0] n4_px, n5_px, n6_px, n7_px;
    logic [31:0] r4_px, r5_px, r6_px, r7_px;
    t_marks      r4_m, r5_m;
    logic        r4_v, r5_v, r6_v, r7_v;
    logic        r6_tl, r6_tr;

    always_comb begin
        // grid column, column label box
        n4_px = i_px;
        if (i_marks.gx) begin
            n4_px = mix(n4_px, 8'd0, 8'd255, 8'd255, GRID_ALPHA);
        end
        if (i_marks.cbox) begin
            n4_px = mix(n4_px, 8'd0, 8'd0, 8'd0, BOX_ALPHA);
        end
        // column glyph, grid row, row label box
        n5_px = r4_px;
        if (r4_m.cglyph) begin
            n5_px = {r4_px[31:24], 24'hFF_FFFF} | WHITE_RGB;
        end
        if (r4_m.gy) begin
            n5_px = mix(n5_px, 8'd0, 8'd255, 8'd255, GRID_ALPHA);
        end
        if (r4_m.rbox) begin
            n5_px = mix(n5_px, 8'd0, 8'd0, 8'd0, BOX_ALPHA);
        end
        // row glyph, top and bottom ticks
        n6_px = r5_px;
        if (r5_m.rglyph) begin
            n6_px = {r5_px[31:24], 24'hFF_FFFF};
        end
        if (r5_m.ttop) begin
            n6_px = mix(n6_px, 8'd255, TICK_GREEN, 8'd0, TICK_ALPHA);
        end
        if (r5_m.tbot) begin
            n6_px = mix(n6_px, 8'd255, TICK_GREEN, 8'd0, TICK_ALPHA);
        end
        // left and right ticks
        n7_px = r6_px;
        if (r6_tl) begin
            n7_px = mix(n7_px, 8'd255, TICK_GREEN, 8'd0, TICK_ALPHA);
        end
        if (r6_tr) begin
            n7_px = mix(n7_px, 8'd255, TICK_GREEN, 8'd0, TICK_ALPHA);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (i_adv) begin
            r4_v <= i_valid;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
        if (i_adv) begin
            r4_px <= n4_px;
            r4_m  <= i_marks;
            r5_px <= n5_px;
            r5_m  <= r4_m;
            r6_px <= n6_px;
            r6_tl <= r5_m.tleft;
            r6_tr <= r5_m.tright;
            r7_px <= n7_px;
        end
    end

    assign o_valid = r7_v;
    assign o_px    = r7_px;

endmodule

### rtl/cgo_checker.sv
module cgo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_pixel_out
);

    logic [3:0] r_inflight;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 4'd0;
        end else begin
            r_inflight <= r_inflight + 4'(i_valid && o_ready) - 4'(o_valid && i_ready);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_out))
        else $error("output word changed while stalled");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 4'd7)
        else $error("more words in flight than pipeline stages");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight != 4'd0)
        else $error("output word without a matching input word");

    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked while output is empty");

endmodule

bind coordinate_grid_overlay_unit cgo_checker u_cgo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_pixel_out (o_pixel_out)
);
